>>> rtl/sspc_pkg.sv
package sspc_pkg;

    localparam int TIME_SHIFT_DEF = 10;
    localparam int STEP_UNITS     = 256;
    localparam int STEP_SHIFT     = 8;
    localparam int PID_SHIFT      = 10;
    localparam int WRAP_LIMIT     = 51200;
    localparam int WRAP_BIAS      = 32'h0100_0000;
    localparam int DIV_NUM_W      = 48;
    localparam int DIV_DEN_W      = 32;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_TORQUE = 2'd2,
        MODE_PID    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_SPR    = 3'd1,
        REG_MULT   = 3'd2,
        REG_RUN    = 3'd3,
        REG_HOLD   = 3'd4,
        REG_GAIN_P = 3'd5,
        REG_GAIN_I = 3'd6,
        REG_GAIN_D = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PROD, ST_PHASE, ST_DIFF, ST_ERR, ST_INT, ST_ACC,
        ST_WAIT, ST_SUM, ST_CO, ST_SCALE, ST_FINISH, ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/sspc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sspc_div
    import sspc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output div_stat_t            stat,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        if (!trial[DIV_DEN_W])
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

>>> rtl/servo_stepper_phase_controller.sv
// Closed-loop stepper phase controller.
// Input items arrive on the s_ channel: encoder position, commanded step position
// and a free-running timer value. Each item gives at most one result item on the
// m_ channel: drive phase, coil current scale and the accumulated tracking error.
// Registers are written on the cfg_ channel, which is always ready; they are to be
// written only while the block is idle, which the block itself does not enforce.
// Writing pid mode clears the loop state and arms a capture: the next item only
// records the phase offset and the timer value and gives no result. Disabled mode
// swallows items without a result. Open loop and torque items go from the product
// and phase steps to the output register. A pid loop item passes the difference,
// error, integral and accumulate steps, waits for the bit-serial divider of the
// derivative term (one quotient bit per cycle over 48 bits), then passes the sum,
// output, scale and finish steps. Disabled and capture items end at the phase step.
// The block works on one item at a time; s_tready is high while it is idle,
// also while a finished result still waits in the output register.
// If the receiver stalls, the result is held and a later result waits in its
// last step until the output register is free.
// Reset covers the state, valid, configuration and loop registers, not the data ones.
module servo_stepper_phase_controller
    import sspc_pkg::*;
#(
    parameter int TIME_SHIFT = TIME_SHIFT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // encoder position, commanded position, timer value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // drive_phase, current_scale, tracking_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    // Configuration registers.
    mode_t              mode_reg;
    logic [15:0]        spr_reg, mult_reg, run_reg;
    logic [31:0]        hoe_reg;
    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg;

    // Loop state.
    logic [31:0]        offset_reg, prev_phase_reg, prev_cmd_reg, prev_time_reg;
    logic [31:0]        error_sum_reg;
    logic signed [9:0]  integral_reg;
    logic               capture_reg;

    // Per-item working registers.
    logic [31:0]        enc_reg, cmd_reg, now_reg;
    logic [31:0]        prod_reg, stp_reg, phase_reg;
    logic signed [31:0] dts_reg, pdiff_reg;
    logic signed [9:0]  errc_reg, co_reg;
    logic signed [47:0] dprod_reg;
    logic signed [41:0] ip_reg;
    logic signed [25:0] pterm_reg, iterm_reg;
    logic signed [49:0] sum_reg;
    logic               qneg_reg;
    logic [31:0]        sprod_reg;
    logic [31:0]        res_phase_reg;
    logic [15:0]        res_scale_reg;

    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    // Combinational helpers.
    logic [31:0]        tp_sum, tp, tdiff, dt_raw, dt_fix;
    logic signed [31:0] pd_raw, pdiff, es;
    logic [31:0]        err_new;
    logic signed [9:0]  errc, int_clamp, co_clamp;
    logic signed [42:0] int_sum;
    logic signed [47:0] dprod;
    logic [47:0]        num_abs;
    logic [31:0]        den_abs;
    logic signed [48:0] quo_s;
    logic signed [49:0] sum_adj, co_raw;
    logic [9:0]         co_abs;
    logic [31:0]        diff_rh, scale32, phase_target;
    logic               div_start, out_load;
    div_stat_t          div_stat;
    logic [47:0]        div_quo;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Encoder position to phase, with rounding to the nearest step unit.
    assign tp_sum = prod_reg + 32'(STEP_UNITS / 2);
    assign tp     = {8'd0, tp_sum[31:STEP_SHIFT]};

    // Scaled time step; a zero step counts as one.
    assign tdiff  = now_reg - prev_time_reg;
    assign dt_raw = tdiff >> TIME_SHIFT;
    assign dt_fix = (dt_raw == '0) ? 32'd1 : dt_raw;

    // Phase difference with encoder wrap correction.
    always_comb
    begin
        pd_raw = phase_reg - prev_phase_reg;
        if (pd_raw > 32'(WRAP_LIMIT))
            pdiff = pd_raw - 32'(WRAP_BIAS);
        else if (pd_raw < -32'(WRAP_LIMIT))
            pdiff = pd_raw + 32'(WRAP_BIAS);
        else
            pdiff = pd_raw;
    end

    assign err_new = error_sum_reg + (stp_reg - prev_cmd_reg) - pdiff;

    // Following error clamped to one full step.
    always_comb
    begin
        es = error_sum_reg;
        if (es > 32'sd256)
            errc = 10'sd256;
        else if (es < -32'sd256)
            errc = -10'sd256;
        else
            errc = es[9:0];
    end

    always_comb
    begin
        int_sum = integral_reg + ip_reg;
        if (int_sum > 43'sd256)
            int_clamp = 10'sd256;
        else if (int_sum < -43'sd256)
            int_clamp = -10'sd256;
        else
            int_clamp = int_sum[9:0];
    end

    assign dprod   = gain_d_reg * pdiff_reg;
    assign num_abs = dprod_reg[47] ? 48'(-dprod_reg) : 48'(dprod_reg);
    assign den_abs = dts_reg[31] ? 32'(-dts_reg) : 32'(dts_reg);
    assign quo_s   = qneg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // Controller output: divide by 1024 toward zero, then clamp to one step.
    always_comb
    begin
        sum_adj = sum_reg + (sum_reg[49] ? 50'sd1023 : 50'sd0);
        co_raw  = sum_adj >>> PID_SHIFT;
        if (co_raw > 50'sd256)
            co_clamp = 10'sd256;
        else if (co_raw < -50'sd256)
            co_clamp = -10'sd256;
        else
            co_clamp = co_raw[9:0];
    end

    assign co_abs  = co_reg[9] ? 10'(-co_reg) : 10'(co_reg);
    assign diff_rh = {16'd0, run_reg} - hoe_reg;
    assign scale32 = {8'd0, sprod_reg[31:STEP_SHIFT]} + hoe_reg;

    // Large error: measured phase pushed by the clamped error; otherwise the scaled command.
    always_comb
    begin
        if ($signed(error_sum_reg) > 32'sd128 || $signed(error_sum_reg) < -32'sd128)
            phase_target = phase_reg + {{22{errc_reg[9]}}, errc_reg};
        else
            phase_target = stp_reg;
    end

    assign div_start = (state_reg == ST_INT);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    sspc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_abs),
        .den   (den_abs),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_PROD;
            end
            ST_PROD:  state_next = ST_PHASE;
            ST_PHASE:
            begin
                case (mode_reg)
                    MODE_OPEN, MODE_TORQUE: state_next = ST_DONE;
                    MODE_PID:   state_next = capture_reg ? ST_IDLE : ST_DIFF;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_DIFF:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_INT;
            ST_INT:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_SUM;
            end
            ST_SUM:    state_next = ST_CO;
            ST_CO:     state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Configuration and loop state; configuration must arrive only while idle, which the block does not check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            spr_reg        <= 16'd200;
            mult_reg       <= 16'd1;
            run_reg        <= '0;
            hoe_reg        <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            offset_reg     <= '0;
            prev_phase_reg <= '0;
            prev_cmd_reg   <= '0;
            prev_time_reg  <= '0;
            error_sum_reg  <= '0;
            integral_reg   <= '0;
            capture_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:
                begin
                    mode_reg <= mode_t'(cfg_data[1:0]);
                    if (mode_t'(cfg_data[1:0]) == MODE_PID)
                    begin
                        prev_phase_reg <= '0;
                        prev_cmd_reg   <= '0;
                        error_sum_reg  <= '0;
                        integral_reg   <= '0;
                        capture_reg    <= 1'b1;
                    end
                    else
                        capture_reg <= 1'b0;
                end
                REG_SPR:    spr_reg    <= cfg_data[15:0];
                REG_MULT:   mult_reg   <= cfg_data[15:0];
                REG_RUN:    run_reg    <= cfg_data[15:0];
                REG_HOLD:   hoe_reg    <= cfg_data;
                REG_GAIN_P: gain_p_reg <= cfg_data[15:0];
                REG_GAIN_I: gain_i_reg <= cfg_data[15:0];
                REG_GAIN_D: gain_d_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
        else
        begin
            case (state_reg)
                ST_PHASE:
                begin
                    if (mode_reg == MODE_PID && capture_reg)
                    begin
                        offset_reg    <= tp;
                        prev_time_reg <= now_reg;
                        capture_reg   <= 1'b0;
                    end
                end
                ST_DIFF: error_sum_reg <= err_new;
                ST_ACC:  integral_reg  <= int_clamp;
                ST_FINISH:
                begin
                    prev_phase_reg <= phase_reg;
                    prev_cmd_reg   <= stp_reg;
                    prev_time_reg  <= now_reg;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                enc_reg <= s_tdata[31:0];
                cmd_reg <= s_tdata[63:32];
                now_reg <= s_tdata[95:64];
            end
            ST_PROD:
            begin
                prod_reg <= 32'({16'd0, spr_reg} * enc_reg);
                stp_reg  <= 32'({16'd0, mult_reg} * cmd_reg);
            end
            ST_PHASE:
            begin
                phase_reg     <= tp - offset_reg;
                dts_reg       <= dt_fix;
                res_scale_reg <= run_reg;
                if (mode_reg == MODE_OPEN)
                    res_phase_reg <= stp_reg;
                else
                    res_phase_reg <= tp + hoe_reg;
            end
            ST_DIFF: pdiff_reg <= pdiff;
            ST_ERR:
            begin
                errc_reg  <= errc;
                dprod_reg <= dprod;
            end
            ST_INT:
            begin
                ip_reg    <= errc_reg * dts_reg;
                pterm_reg <= gain_p_reg * errc_reg;
                qneg_reg  <= dprod_reg[47] ^ dts_reg[31];
            end
            ST_WAIT:   iterm_reg <= gain_i_reg * integral_reg;
            ST_SUM:    sum_reg   <= pterm_reg + iterm_reg - quo_s;
            ST_CO:     co_reg    <= co_clamp;
            ST_SCALE:  sprod_reg <= 32'({23'd0, co_abs[8:0]} * diff_rh);
            ST_FINISH:
            begin
                res_phase_reg <= phase_target;
                res_scale_reg <= scale32[15:0];
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {error_sum_reg, res_scale_reg, res_phase_reg};
    end

endmodule

>>> rtl/sspc_check.sv
module sspc_check
    import sspc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One item at a time: the block is busy right after it takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // No result can appear in the cycle right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // A new result is loaded only from the final busy step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while idle");

endmodule

bind servo_stepper_phase_controller sspc_check u_check (.*);

>>> bench/servo_stepper_phase_controller_tb.sv
`timescale 1ns / 1ps

module servo_stepper_phase_controller_tb
    import sspc_pkg::*;
();

    typedef struct packed {
        logic [31:0] timer;
        logic [31:0] commanded;
        logic [31:0] encoder;
    } sample_t;

    typedef struct packed {
        logic [31:0] tracking_error;
        logic [15:0] current_scale;
        logic [31:0] drive_phase;
    } drive_t;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // encoder position, commanded position, timer value
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // drive_phase, current_scale, tracking_error
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    servo_stepper_phase_controller uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Samples waiting to be offered, and drive results predicted but not yet seen.
    sample_t pending_samples[$];
    drive_t  expected_drives[$];

    int error_count;
    int samples_sent;
    int drives_seen;
    int cycle_count;

    // Register copy kept by the predictor.
    mode_t       mode;
    logic [15:0] steps_per_rot;
    logic [15:0] multiplier;
    logic [15:0] run_cur;
    logic [31:0] hold_exc;
    shortint     kp;
    shortint     ki;
    shortint     kd;

    // Loop state kept by the predictor.
    logic [31:0] offset_phase;
    logic [31:0] prior_phase;
    logic [31:0] last_cmd;
    logic [31:0] last_time;
    logic [31:0] err_acc;
    longint      integ;
    bit          capture_armed;

    // Long receiver hold-off requested by the stimulus.
    bit hold_request;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic longint limit_steps(input longint v);
        if (v < -STEP_UNITS)
            return -STEP_UNITS;
        if (v > STEP_UNITS)
            return STEP_UNITS;
        return v;
    endfunction

    function automatic logic [31:0] encoder_phase(input logic [31:0] pos);
        logic [31:0] prod;
        prod = 32'(steps_per_rot) * pos;
        prod = prod + 32'd128;
        return prod >> 8;
    endfunction

    function automatic void apply_register(input reg_idx_t idx, input logic [31:0] value);
        case (idx)
            REG_MODE:
            begin
                mode = mode_t'(value[1:0]);
                if (mode == MODE_PID)
                begin
                    prior_phase   = '0;
                    last_cmd      = '0;
                    err_acc       = '0;
                    integ         = 0;
                    capture_armed = 1'b1;
                end
                else
                    capture_armed = 1'b0;
            end
            REG_SPR:    steps_per_rot = value[15:0];
            REG_MULT:   multiplier    = value[15:0];
            REG_RUN:    run_cur       = value[15:0];
            REG_HOLD:   hold_exc      = value;
            REG_GAIN_P: kp            = shortint'(value[15:0]);
            REG_GAIN_I: ki            = shortint'(value[15:0]);
            default:    kd            = shortint'(value[15:0]);
        endcase
    endfunction

    // Computes the drive result for one sample; returns 0 when none is due.
    function automatic bit compute_drive(input sample_t smp, output drive_t res);
        logic [31:0] dt;
        logic [31:0] phase;
        logic [31:0] stp;
        logic [31:0] mag;
        logic [31:0] scale;
        logic [31:0] nxt;
        longint      dts;
        longint      pdiff;
        longint      err;
        longint      errc;
        longint      total;
        longint      co;
        res = '0;
        case (mode)
            MODE_OPEN:
            begin
                res.drive_phase    = smp.commanded * 32'(multiplier);
                res.current_scale  = run_cur;
                res.tracking_error = err_acc;
                return 1'b1;
            end
            MODE_TORQUE:
            begin
                res.drive_phase    = encoder_phase(smp.encoder) + hold_exc;
                res.current_scale  = run_cur;
                res.tracking_error = err_acc;
                return 1'b1;
            end
            MODE_OFF:
                return 1'b0;
            default:
            begin
            end
        endcase
        if (capture_armed)
        begin
            offset_phase  = encoder_phase(smp.encoder);
            last_time     = smp.timer;
            capture_armed = 1'b0;
            return 1'b0;
        end
        dt = (smp.timer - last_time) >> TIME_SHIFT_DEF;
        if (dt == 0)
            dt = 1;
        dts = longint'(signed'(dt));
        phase = encoder_phase(smp.encoder) - offset_phase;
        pdiff = longint'(signed'(phase - prior_phase));
        if (pdiff > WRAP_LIMIT)
            pdiff -= WRAP_BIAS;
        else if (pdiff < -WRAP_LIMIT)
            pdiff += WRAP_BIAS;
        stp = smp.commanded * 32'(multiplier);
        err_acc = err_acc + (stp - last_cmd) - pdiff[31:0];
        err  = longint'(signed'(err_acc));
        errc = limit_steps(err);
        integ = limit_steps(integ + errc * dts);
        total = longint'(kp) * errc + longint'(ki) * integ - (longint'(kd) * pdiff) / dts;
        co  = limit_steps(total / 1024);
        mag = (co < 0) ? 32'(-co) : 32'(co);
        scale = mag * (32'(run_cur) - hold_exc);
        scale = (scale >> 8) + hold_exc;
        if (err > STEP_UNITS / 2 || err < -(STEP_UNITS / 2))
            nxt = phase + errc[31:0];
        else
            nxt = stp;
        res.drive_phase    = nxt;
        res.current_scale  = scale[15:0];
        res.tracking_error = err_acc;
        prior_phase = phase;
        last_cmd    = stp;
        last_time   = smp.timer;
        return 1'b1;
    endfunction

    // Sender: bursts of random length separated by random gaps. The prediction
    // is made at the edge where the sample is accepted.
    int burst_left;
    int gap_left;

    always @(posedge clk)
    begin
        sample_t smp;
        drive_t  res;
        bit      show;
        if (rst_n)
        begin
            cycle_count++;
            if (s_tvalid && s_tready)
            begin
                smp = pending_samples.pop_front();
                samples_sent++;
                if (compute_drive(smp, res))
                    expected_drives.push_back(res);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else if (!s_tvalid && gap_left > 0)
                gap_left--;
            show = (gap_left == 0) && (pending_samples.size() > 0);
            s_tvalid <= show;
            s_tdata  <= show ? 96'(pending_samples[0]) : s_tdata;
        end
    end

    // Receiver: the stall pattern is picked anew at regular points between always
    // ready, mostly ready and a coin toss. A hold-off request holds it low once.
    int stall_style;
    int hold_left;
    bit hold_done;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cycle_count % 64 == 0)
                stall_style = $urandom_range(0, 2);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_style == 0)
                m_tready <= 1'b1;
            else if (stall_style == 1)
                m_tready <= ($urandom_range(0, 7) != 0);
            else
                m_tready <= $urandom_range(0, 1);
        end
    end

    // Monitor: every accepted result must match the oldest prediction.
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = drive_t'(m_tdata);
            drives_seen++;
            if (expected_drives.size() == 0)
                report("unexpected result, drive_phase", got.drive_phase, 32'd0);
            else
            begin
                want = expected_drives.pop_front();
                if (got.drive_phase !== want.drive_phase)
                    report("drive_phase", got.drive_phase, want.drive_phase);
                if (got.current_scale !== want.current_scale)
                    report("current_scale", 32'(got.current_scale), 32'(want.current_scale));
                if (got.tracking_error !== want.tracking_error)
                    report("tracking_error", got.tracking_error, want.tracking_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("servo_stepper_phase_controller_tb: errors");
            $finish;
        end
    end

    // Waits until all samples are taken and all results are seen, then lets the
    // block finish an item that gives no result.
    task automatic drain();
        while (pending_samples.size() > 0 || s_tvalid || expected_drives.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Writes one register; called just after clk rises. The caller lowers
    // cfg_valid after the last write so that it stays high across a sequence.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
    endtask

    task automatic setup(input mode_t m, input logic [15:0] spr, input logic [15:0] mult,
                         input logic [15:0] run, input logic [31:0] hold,
                         input logic [15:0] gp, input logic [15:0] gi, input logic [15:0] gd);
        drain();
        write_reg(REG_SPR, 32'(spr));
        write_reg(REG_MULT, 32'(mult));
        write_reg(REG_RUN, 32'(run));
        write_reg(REG_HOLD, hold);
        write_reg(REG_GAIN_P, 32'(gp));
        write_reg(REG_GAIN_I, 32'(gi));
        write_reg(REG_GAIN_D, 32'(gd));
        write_reg(REG_MODE, 32'(m));
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_sample(input logic [31:0] enc, input logic [31:0] cmd,
                                       input logic [31:0] tm);
        sample_t smp;
        smp.encoder   = enc;
        smp.commanded = cmd;
        smp.timer     = tm;
        pending_samples.push_back(smp);
    endfunction

    // A plausible servo trace: the command creeps, the encoder drifts with noise
    // and the timer advances, sometimes not at all. A few items are pure noise.
    function automatic void add_trace(input int count);
        logic [31:0] cmd;
        logic [31:0] enc;
        logic [31:0] tm;
        cmd = $urandom;
        enc = $urandom;
        tm  = $urandom;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       add_sample($urandom, $urandom, $urandom);
                1:
                begin
                    enc = enc + $urandom_range(0, 1 << 20) - (1 << 19);
                    add_sample(enc, cmd, tm);
                end
                default:
                begin
                    cmd = cmd + $urandom_range(0, 10) - 5;
                    enc = enc + $urandom_range(0, 4000) - 2000;
                    tm  = tm + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                            : $urandom_range(0, 300000));
                    add_sample(enc, cmd, tm);
                end
            endcase
        end
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MODE;
        cfg_data      = '0;
        error_count   = 0;
        samples_sent  = 0;
        drives_seen   = 0;
        cycle_count   = 0;
        burst_left    = 8;
        gap_left      = 0;
        stall_style   = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        hold_request  = 1'b0;
        mode          = MODE_OFF;
        steps_per_rot = 16'd200;
        multiplier    = 16'd1;
        run_cur       = '0;
        hold_exc      = '0;
        kp            = 0;
        ki            = 0;
        kd            = 0;
        offset_phase  = '0;
        prior_phase   = '0;
        last_cmd      = '0;
        last_time     = '0;
        err_acc       = '0;
        integ         = 0;
        capture_armed = 1'b0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state is disabled mode, which swallows samples.
        add_sample('0, '0, '0);
        add_sample('1, '1, '1);
        setup(MODE_OPEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF);
        add_sample('1, '1, '1);
        add_sample('0, '0, '0);
        add_sample(32'h8000_0000, 32'h8000_0001, 32'h0);
        setup(MODE_TORQUE, 16'd1, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
        add_sample('1, '0, '0);
        add_sample(32'h0000_0080, '1, '1);
        add_sample(32'h0000_007F, '1, '1);
        // Pid: capture, zero time step, phase wrap both ways, large error.
        setup(MODE_PID, 16'd200, 16'd256, 16'd1000, 32'd100, 16'd2000, 16'd500, 16'd300);
        add_sample(32'd1000, 32'd0, 32'd0);
        add_sample(32'd1000, 32'd0, 32'd0);
        add_sample(32'd1000, 32'd1, 32'd1024);
        add_sample(32'h0400_0000, 32'd1, 32'd4096);
        add_sample(32'd0, 32'd1, 32'd8192);
        add_sample(32'd5000, 32'd50, 32'h0010_0000);
        add_sample(32'd5000, 32'd50, 32'hFFFF_FFFF);
        setup(MODE_PID, 16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF);
        add_sample('1, '1, '1);
        add_sample('0, '1, '0);
        add_sample('1, '0, '1);

        // Random phases over all modes with random and extreme settings.
        for (int p = 0; p < 14; p++)
        begin
            mode_t m;
            m = (p % 7 == 6) ? MODE_OFF : ((p % 3 == 0) ? MODE_OPEN
                : ((p % 3 == 1) ? MODE_TORQUE : MODE_PID));
            if (p > 3)
                m = (p % 2 == 0) ? MODE_PID : m;
            setup(m, (pick16() == 0) ? 16'd200 : pick16(), pick16(), pick16(),
                  ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 65535)) : $urandom,
                  pick16(), pick16(), pick16());
            if (p == 5)
                hold_request = 1'b1;
            add_trace(95);
        end

        drain();
        $display("run covered %0d samples, %0d results checked, in all four modes",
                 samples_sent, drives_seen);
        $display("including pid capture, zero time steps, phase wrap and a long output stall");
        if (error_count == 0)
            $display("servo_stepper_phase_controller_tb: clean");
        else
            $display("servo_stepper_phase_controller_tb: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/sspc_pkg.sv
rtl/sspc_div.sv
rtl/servo_stepper_phase_controller.sv
rtl/sspc_check.sv
bench/servo_stepper_phase_controller_tb.sv
